### sv/pcps_pkg.sv
// pcps_pkg: shared types, codes and constants for the polar scan builder
// holds the arctangent table entry function used at elaboration
// no dependencies
package pcps_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_POINT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_ANGLE_START = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_RANGE_FLOOR = 3'd2,
    REG_RANGE_CEIL  = 3'd3,
    REG_BINS_IN_USE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } iter_req_t;

  localparam int          REM_W      = 18;
  localparam int          OPND_W     = 32;
  localparam int          CNT_W      = 5;
  localparam logic [4:0]  SQRT_LAST  = 5'd15;
  localparam logic [4:0]  DIV_LAST   = 5'd31;
  localparam int          TAB_W      = 14;
  localparam logic signed [17:0] ANG_PI      = 18'sd25736;
  localparam logic signed [17:0] ANG_HALF_PI = 18'sd12868;

  // shift and subtract division, evaluated at elaboration only
  function automatic longint unsigned const_div(input longint unsigned a,
                                                input longint unsigned b);
    longint unsigned rem;
    longint unsigned quo;
    rem = 0;
    quo = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem = rem - b;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(j/n) in 2^-13 rad via euler series in q30
  function automatic logic [13:0] atan_entry(input longint unsigned n,
                                             input longint unsigned j);
    longint unsigned den;
    longint unsigned t;
    longint unsigned yq;
    longint unsigned sum;
    longint unsigned kk;
    den = n * n + j * j;
    t   = const_div((j * n) << 30, den);
    yq  = const_div((j * j) << 30, den);
    sum = t;
    for (int k = 1; k <= 63; k++) begin
      kk  = longint'(k);
      t   = (t * yq) >> 30;
      t   = const_div(t * (2 * kk), 2 * kk + 1);
      sum = sum + t;
    end
    return 14'((sum + 64'd65536) >> 17);
  endfunction

endpackage

### sv/point_cloud_to_polar_scan.sv
// point_cloud_to_polar_scan: top level, sequencer, multiplier, bin store and registers
// depends on pcps_pkg, pcps_iter, pcps_atan_rom, pcps_ram
//
//  channel | direction | handshake               | fields
//  in      | input     | in_valid_i / in_stall_o | op, point_x_mm, point_y_mm, read_bin
//  out     | output    | out_valid_o/out_stall_i | bin_range_mm, bin_outside
//  cfg     | apb       | psel penable pwrite     | paddr, pwdata, prdata
//
// a point word runs through the shared root and divide unit:
// 16 root steps plus two 32 step divisions, plus multiply and bin update states
// a clear word and reset both run a clearing pass over all MAX_BINS entries
// a read word waits while the output register is stalled
// input is taken only between words
module point_cloud_to_polar_scan #(
  parameter int MAX_BINS   = 1024,
  parameter int ATAN_STEPS = 200
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic signed [15:0] point_x_mm_i,
  input  logic signed [15:0] point_y_mm_i,
  input  logic [9:0]         read_bin_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        bin_range_mm_o,
  output logic               bin_outside_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int IW = $clog2(ATAN_STEPS + 1);
  localparam logic [AW-1:0] LAST_BIN = AW'(MAX_BINS - 1);
  localparam logic [15:0]   TWO_N    = 16'(2 * ATAN_STEPS);
  localparam logic [15:0]   MAXB16   = 16'(MAX_BINS);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_SQ_X     = 15'h0004,
    S_SQ_Y     = 15'h0008,
    S_SQ_SUM   = 15'h0010,
    S_SQRT_RUN = 15'h0020,
    S_RANGE    = 15'h0040,
    S_ATAN_RUN = 15'h0080,
    S_ANGLE    = 15'h0100,
    S_STEP_GO  = 15'h0200,
    S_STEP_RUN = 15'h0400,
    S_BIN_RD   = 15'h0800,
    S_BIN_WR   = 15'h1000,
    S_RD_WAIT  = 15'h2000,
    S_OUT      = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] angle_start_q;
  logic [13:0] angle_step_q;
  logic [15:0] floor_q;
  logic [15:0] ceil_q;
  logic [10:0] bins_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= 16'h9B78;
      angle_step_q  <= 14'd143;
      floor_q       <= 16'd100;
      ceil_q        <= 16'd30000;
      bins_q        <= 11'd360;
    end else if (cfg_we) begin
      unique case (pcps_pkg::reg_idx_e'(paddr[4:2]))
        pcps_pkg::REG_ANGLE_START: angle_start_q <= pwdata[15:0];
        pcps_pkg::REG_ANGLE_STEP:  angle_step_q  <= pwdata[13:0];
        pcps_pkg::REG_RANGE_FLOOR: floor_q       <= pwdata[15:0];
        pcps_pkg::REG_RANGE_CEIL:  ceil_q        <= pwdata[15:0];
        pcps_pkg::REG_BINS_IN_USE: bins_q        <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pcps_pkg::reg_idx_e'(paddr[4:2]))
      pcps_pkg::REG_ANGLE_START: prdata = {16'b0, angle_start_q};
      pcps_pkg::REG_ANGLE_STEP:  prdata = {18'b0, angle_step_q};
      pcps_pkg::REG_RANGE_FLOOR: prdata = {16'b0, floor_q};
      pcps_pkg::REG_RANGE_CEIL:  prdata = {16'b0, ceil_q};
      pcps_pkg::REG_BINS_IN_USE: prdata = {21'b0, bins_q};
      default:                   prdata = '0;
    endcase
  end

  // word registers
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic               outside_q, outside_d;
  logic [15:0]        r_q, r_d;
  logic [31:0]        sq_q, sq_d;
  logic [31:0]        prod_q;
  logic [IW-1:0]      idx_q, idx_d;
  logic signed [17:0] d_q, d_d;
  logic signed [18:0] kf_q, kf_d;
  logic signed [18:0] kc_q, kc_d;
  logic               second_q, second_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        out_range_q, out_range_d;
  logic               out_outside_q, out_outside_d;

  // operands
  logic [15:0] ax, ay, num, den;
  logic        swap, origin;
  logic [15:0] cnt16;
  logic [15:0] ceil_sat;
  logic        rd_outside;
  logic [15:0] rb16;

  assign ax       = x_q[15] ? 16'(-x_q) : 16'(x_q);
  assign ay       = y_q[15] ? 16'(-y_q) : 16'(y_q);
  assign swap     = ay > ax;
  assign num      = swap ? ax : ay;
  assign den      = swap ? ay : ax;
  assign origin   = (ax == '0) && (ay == '0);
  assign cnt16    = ({5'b0, bins_q} > MAXB16) ? MAXB16 : {5'b0, bins_q};
  assign ceil_sat = (ceil_q == 16'hFFFF) ? 16'hFFFF : ceil_q + 16'd1;
  assign rb16     = {6'b0, read_bin_i};
  assign rd_outside = rb16 >= cnt16;

  // shared multiplier, registered
  logic [15:0] mul_a, mul_b;
  logic        mul_en;

  always_comb begin
    mul_a  = ax;
    mul_b  = ax;
    mul_en = 1'b1;
    unique case (state_q)
      S_SQ_X:   begin mul_a = ax;  mul_b = ax;    end
      S_SQ_Y:   begin mul_a = ay;  mul_b = ay;    end
      S_SQ_SUM: begin mul_a = num; mul_b = TWO_N; end
      default:  mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= 32'(mul_a) * 32'(mul_b);
    end
  end

  // shared root and divide unit
  pcps_pkg::iter_req_t iter_req;
  logic [31:0]         iter_opnd;
  logic [16:0]         iter_div;
  logic                iter_done;
  logic [31:0]         iter_quo;
  logic                iter_rnz;

  pcps_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (iter_req),
    .operand_i (iter_opnd),
    .divisor_i (iter_div),
    .done_o    (iter_done),
    .quo_o     (iter_quo),
    .rem_nz_o  (iter_rnz)
  );

  // arctangent table
  logic [pcps_pkg::TAB_W-1:0] tab_val;

  pcps_atan_rom #(.STEPS(ATAN_STEPS)) u_atan (
    .idx_i (idx_q),
    .val_o (tab_val)
  );

  // bin store, msb is the filled flag
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [16:0]   ram_wdata, ram_rdata;

  pcps_ram #(.WIDTH(17), .DEPTH(MAX_BINS)) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // angle and bin index arithmetic
  logic signed [17:0] tab_s, th_fold, th_x, th_a, start_s;
  logic [16:0]        d_abs;
  logic [16:0]        step_eff;
  logic signed [18:0] q_s, qc_s;
  logic signed [18:0] k_cur;
  logic               k_ok;
  logic [31:0]        idx_clamp;

  assign tab_s    = signed'({4'b0, tab_val});
  assign th_fold  = swap ? pcps_pkg::ANG_HALF_PI - tab_s : tab_s;
  assign th_x     = x_q[15] ? pcps_pkg::ANG_PI - th_fold : th_fold;
  assign th_a     = origin ? 18'sd0 : (y_q[15] ? -th_x : th_x);
  assign start_s  = signed'({{2{angle_start_q[15]}}, angle_start_q});
  assign d_abs    = d_q[17] ? 17'(-d_q) : 17'(d_q);
  assign step_eff = (angle_step_q == '0) ? 17'd1 : {3'b0, angle_step_q};
  assign q_s      = signed'({2'b0, iter_quo[16:0]});
  assign qc_s     = q_s + signed'({18'b0, iter_rnz});
  assign k_cur    = second_q ? kc_q : kf_q;
  assign k_ok     = !k_cur[18] && (k_cur[17:0] < {2'b0, cnt16});
  assign idx_clamp = (iter_quo > 32'(ATAN_STEPS)) ? 32'(ATAN_STEPS) : iter_quo;

  // sequencer
  always_comb begin
    state_d        = state_q;
    outside_d      = outside_q;
    r_d            = r_q;
    sq_d           = sq_q;
    idx_d          = idx_q;
    d_d            = d_q;
    kf_d           = kf_q;
    kc_d           = kc_q;
    second_d       = second_q;
    addr_d         = addr_q;
    clr_d          = clr_q;
    out_valid_d    = out_valid_q & out_stall_i;
    out_range_d    = out_range_q;
    out_outside_d  = out_outside_q;
    iter_req       = '0;
    iter_opnd      = '0;
    iter_div       = '0;
    ram_we         = 1'b0;
    ram_waddr      = clr_q;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = rb16[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == LAST_BIN) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (pcps_pkg::op_e'(op_i))
            pcps_pkg::OP_CLEAR: state_d = S_CLEAR;
            pcps_pkg::OP_POINT: state_d = S_SQ_X;
            pcps_pkg::OP_READ: begin
              outside_d = rd_outside;
              ram_re    = !rd_outside;
              state_d   = rd_outside ? S_OUT : S_RD_WAIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SQ_X: state_d = S_SQ_Y;
      S_SQ_Y: begin
        sq_d    = prod_q;
        state_d = S_SQ_SUM;
      end
      S_SQ_SUM: begin
        iter_req.start     = 1'b1;
        iter_req.sqrt_mode = 1'b1;
        iter_opnd          = sq_q + prod_q;
        state_d            = S_SQRT_RUN;
      end
      S_SQRT_RUN: begin
        if (iter_done) begin
          r_d     = iter_quo[15:0];
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        if ((r_q < floor_q) || (r_q > ceil_q)) begin
          state_d = S_IDLE;
        end else if (origin) begin
          state_d = S_ANGLE;
        end else begin
          iter_req.start = 1'b1;
          iter_opnd      = prod_q + {16'b0, den};
          iter_div       = {den, 1'b0};
          state_d        = S_ATAN_RUN;
        end
      end
      S_ATAN_RUN: begin
        if (iter_done) begin
          idx_d   = idx_clamp[IW-1:0];
          state_d = S_ANGLE;
        end
      end
      S_ANGLE: begin
        d_d     = th_a - start_s;
        state_d = S_STEP_GO;
      end
      S_STEP_GO: begin
        iter_req.start = 1'b1;
        iter_opnd      = {15'b0, d_abs};
        iter_div       = step_eff;
        state_d        = S_STEP_RUN;
      end
      S_STEP_RUN: begin
        if (iter_done) begin
          kf_d     = d_q[17] ? -qc_s : q_s;
          kc_d     = d_q[17] ? -q_s : qc_s;
          second_d = 1'b0;
          state_d  = S_BIN_RD;
        end
      end
      S_BIN_RD: begin
        if (k_ok) begin
          ram_re    = 1'b1;
          ram_raddr = k_cur[AW-1:0];
          addr_d    = k_cur[AW-1:0];
          state_d   = S_BIN_WR;
        end else if (!second_q && (kc_q != kf_q)) begin
          second_d = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BIN_WR: begin
        ram_waddr = addr_q;
        ram_wdata = {1'b1, r_q};
        ram_we    = !ram_rdata[16] || (r_q < ram_rdata[15:0]);
        if (!second_q && (kc_q != kf_q)) begin
          second_d = 1'b1;
          state_d  = S_BIN_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD_WAIT: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_outside_d = outside_q;
          out_range_d   = outside_q ? 16'd0 :
                          (ram_rdata[16] ? ram_rdata[15:0] : ceil_sat);
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      x_q <= point_x_mm_i;
      y_q <= point_y_mm_i;
    end
    outside_q     <= outside_d;
    r_q           <= r_d;
    sq_q          <= sq_d;
    idx_q         <= idx_d;
    d_q           <= d_d;
    kf_q          <= kf_d;
    kc_q          <= kc_d;
    addr_q        <= addr_d;
    out_range_q   <= out_range_d;
    out_outside_q <= out_outside_d;
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign bin_range_mm_o = out_range_q;
  assign bin_outside_o  = out_outside_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result word without read sequence");

  a_iter_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_done |-> (state_q == S_SQRT_RUN || state_q == S_ATAN_RUN ||
                   state_q == S_STEP_RUN))
    else $error("iterative unit finished outside a wait state");

  a_ram_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_BIN_WR))
    else $error("bin store written outside clear or update");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bin_outside_o) |-> (bin_range_mm_o == 16'd0))
    else $error("outside read with nonzero range");

endmodule

### sv/pcps_ram.sv
// pcps_ram: generic single write port ram with registered read
// no dependencies
module pcps_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/pcps_atan_rom.sv
// pcps_atan_rom: arctangent table, entry j is atan(j/STEPS) in 2^-13 rad
// depends on pcps_pkg
module pcps_atan_rom #(
  parameter int STEPS = 200
) (
  input  logic [$clog2(STEPS+1)-1:0]   idx_i,
  output logic [pcps_pkg::TAB_W-1:0]   val_o
);

  logic [pcps_pkg::TAB_W-1:0] rom [STEPS+1];

  for (genvar j = 0; j <= STEPS; j++) begin : g_tab
    assign rom[j] = pcps_pkg::atan_entry(64'(STEPS), 64'(j));
  end

  assign val_o = rom[idx_i];

endmodule

### sv/pcps_iter.sv
// pcps_iter: shared compare and subtract unit, one digit per cycle
// integer square root (16 steps) or long division (32 steps); depends on pcps_pkg
module pcps_iter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcps_pkg::iter_req_t           req_i,
  input  logic [pcps_pkg::OPND_W-1:0]   operand_i,
  input  logic [16:0]                   divisor_i,
  output logic                          done_o,
  output logic [pcps_pkg::OPND_W-1:0]   quo_o,
  output logic                          rem_nz_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          mode_q, mode_d;
  logic [pcps_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [pcps_pkg::OPND_W-1:0]   opnd_q, opnd_d;
  logic [pcps_pkg::OPND_W-1:0]   quo_q, quo_d;
  logic [pcps_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [16:0]                   div_q, div_d;
  logic [19:0]                   shifted;
  logic [19:0]                   trial;
  logic [19:0]                   diff;
  logic                          ge;

  always_comb begin
    if (mode_q) begin
      shifted = {rem_q, opnd_q[31:30]};
      trial   = {quo_q[17:0], 2'b01};
    end else begin
      shifted = {1'b0, rem_q, opnd_q[31]};
      trial   = {3'b000, div_q};
    end
    ge   = shifted >= trial;
    diff = ge ? shifted - trial : shifted;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    opnd_d = opnd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.sqrt_mode;
      cnt_d  = req_i.sqrt_mode ? pcps_pkg::SQRT_LAST : pcps_pkg::DIV_LAST;
      opnd_d = operand_i;
      quo_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = diff[pcps_pkg::REM_W-1:0];
      quo_d  = {quo_q[30:0], ge};
      opnd_d = mode_q ? {opnd_q[29:0], 2'b00} : {opnd_q[30:0], 1'b0};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = rem_q != '0;

endmodule

### tb/point_cloud_to_polar_scan_tb.sv
// point_cloud_to_polar_scan_tb: self-checking bench for the polar scan builder
// a scoreboard class predicts bin reads from points, clears and registers
// depends on pcps_pkg and point_cloud_to_polar_scan
`timescale 1ns / 100ps

module point_cloud_to_polar_scan_tb;

  localparam int NBINS = 1024;
  localparam int NSTEPS = 200;

  typedef struct {
    logic [15:0] rng;
    logic        outside;
  } scan_word_t;

  class scan_scoreboard;
    logic [15:0] start_q, floor_q, ceil_q;
    logic [13:0] step_q;
    logic [10:0] bins_q;
    int          atan_q[NSTEPS + 1];
    logic [15:0] range_mem[NBINS];
    bit          filled[NBINS];
    scan_word_t  expected[$];
    int          errors;

    function new();
      longint unsigned den, t, yq, sum;
      start_q = 16'h9B78;
      step_q  = 14'd143;
      floor_q = 16'd100;
      ceil_q  = 16'd30000;
      bins_q  = 11'd360;
      errors  = 0;
      for (int i = 0; i < NBINS; i++) filled[i] = 0;
      for (longint unsigned j = 0; j <= NSTEPS; j++) begin
        den = NSTEPS * NSTEPS + j * j;
        t   = ((j * NSTEPS) << 30) / den;
        yq  = ((j * j) << 30) / den;
        sum = t;
        for (longint unsigned k = 1; k <= 63; k++) begin
          t   = (t * yq) >> 30;
          t   = (t * (2 * k)) / (2 * k + 1);
          sum = sum + t;
        end
        atan_q[j] = int'((sum + 64'd65536) >> 17);
      end
    endfunction

    function void set_reg(pcps_pkg::reg_idx_e idx, logic [31:0] v);
      case (idx)
        pcps_pkg::REG_ANGLE_START: start_q = v[15:0];
        pcps_pkg::REG_ANGLE_STEP:  step_q  = v[13:0];
        pcps_pkg::REG_RANGE_FLOOR: floor_q = v[15:0];
        pcps_pkg::REG_RANGE_CEIL:  ceil_q  = v[15:0];
        pcps_pkg::REG_BINS_IN_USE: bins_q  = v[10:0];
        default: ;
      endcase
    endfunction

    function int active_bins();
      return (bins_q > NBINS) ? NBINS : int'(bins_q);
    endfunction

    function longint unsigned root(longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function int table_angle(longint unsigned num, longint unsigned den);
      longint unsigned idx;
      if (den == 0) return 0;
      idx = (2 * NSTEPS * num + den) / (2 * den);
      if (idx > NSTEPS) idx = NSTEPS;
      return atan_q[idx];
    endfunction

    function int polar_angle(int x, int y);
      longint unsigned ax, ay;
      int th;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ay > ax) th = 12868 - table_angle(ax, ay);
      else th = table_angle(ay, ax);
      if (x < 0) th = 25736 - th;
      if (y < 0) th = -th;
      return th;
    endfunction

    function void keep_nearest(int k, logic [15:0] r);
      if (k < 0 || k >= active_bins()) return;
      if (!filled[k] || r < range_mem[k]) begin
        range_mem[k] = r;
        filled[k] = 1;
      end
    endfunction

    function void add_point(int x, int y);
      longint unsigned r;
      int d, stp, kf, kc;
      r = root(longint'(x) * x + longint'(y) * y);
      if (r < floor_q || r > ceil_q) return;
      stp = (step_q == 0) ? 1 : int'(step_q);
      d = polar_angle(x, y) - int'($signed(start_q));
      if (d >= 0) begin
        kf = d / stp;
        kc = (d + stp - 1) / stp;
      end else begin
        kf = -((-d + stp - 1) / stp);
        kc = -((-d) / stp);
      end
      keep_nearest(kf, r[15:0]);
      if (kc != kf) keep_nearest(kc, r[15:0]);
    endfunction

    function void note_input(pcps_pkg::op_e op, logic signed [15:0] x,
                             logic signed [15:0] y, logic [9:0] b);
      scan_word_t w;
      case (op)
        pcps_pkg::OP_CLEAR: for (int i = 0; i < NBINS; i++) filled[i] = 0;
        pcps_pkg::OP_POINT: add_point(int'(x), int'(y));
        pcps_pkg::OP_READ: begin
          if (b >= active_bins()) begin
            w.rng = 16'd0;
            w.outside = 1'b1;
          end else begin
            if (filled[b]) w.rng = range_mem[b];
            else w.rng = (ceil_q == 16'hFFFF) ? 16'hFFFF : ceil_q + 16'd1;
            w.outside = 1'b0;
          end
          expected = {expected, w};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [15:0] rng, logic outside);
      scan_word_t w;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: range %0d outside %0b", rng, outside);
        return;
      end
      w = expected.pop_front();
      if (rng !== w.rng || outside !== w.outside) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: range exp %0d got %0d, outside exp %0b got %0b",
                   w.rng, rng, w.outside, outside);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] op;
  logic signed [15:0] px, py;
  logic [9:0] rbin;
  logic [15:0] bin_range;
  logic bin_outside;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  scan_scoreboard sb;
  int burst_left;
  bit valid_high;
  int hold_req;

  point_cloud_to_polar_scan u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .point_x_mm_i(px), .point_y_mm_i(py), .read_bin_i(rbin),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .bin_range_mm_o(bin_range), .bin_outside_o(bin_outside),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: stall pattern is drawn at random from three modes, long hold on request
  initial begin
    int mode, cnt, hold;
    mode = 0;
    cnt = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(bin_range, bin_outside);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 2);
        cnt = 64;
      end
      cnt--;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (mode == 0) out_stall <= 1'b0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 9) < 3);
      else out_stall <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic drop_valid();
    if (valid_high) begin
      in_valid <= 1'b0;
      valid_high = 0;
    end
  endtask

  task automatic send(pcps_pkg::op_e o, logic signed [15:0] x, logic signed [15:0] y,
                      logic [9:0] b);
    int gap;
    in_valid <= 1'b1;
    valid_high = 1;
    op <= o;
    px <= x;
    py <= y;
    rbin <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(o, x, y, b);
    if (burst_left > 0) burst_left--;
    else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 15);
      if (gap > 0) begin
        drop_valid();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    drop_valid();
    while (sb.expected.size() != 0) @(posedge clk);
  endtask

  // points run through the root and divide unit and clears one full pass, so stay clear of both
  task automatic settle();
    wait_drained();
    repeat (1200) @(posedge clk);
  endtask

  task automatic apb_write(pcps_pkg::reg_idx_e idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(int st, int sp, int fl, int cl, int nb);
    settle();
    apb_write(pcps_pkg::REG_ANGLE_START, 32'(st) & 32'hFFFF);
    apb_write(pcps_pkg::REG_ANGLE_STEP, 32'(sp));
    apb_write(pcps_pkg::REG_RANGE_FLOOR, 32'(fl));
    apb_write(pcps_pkg::REG_RANGE_CEIL, 32'(cl));
    apb_write(pcps_pkg::REG_BINS_IN_USE, 32'(nb));
  endtask

  task automatic random_point();
    int lo, hi, r, x, y;
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 65535) - 32768;
      y = ($urandom_range(0, 1)) ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 600) - 300;
    end else begin
      lo = sb.floor_q;
      hi = (sb.ceil_q > 46340) ? 46340 : sb.ceil_q;
      if (lo > hi) lo = hi;
      r = $urandom_range(lo, hi);
      x = $urandom_range(0, 2 * r) - r;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      y = int'(sb.root(longint'(r) * r - longint'(x) * x));
      if (y > 32767) y = 32767;
      if ($urandom_range(0, 1)) y = -y;
    end
    send(pcps_pkg::OP_POINT, 16'(x), 16'(y), 10'($urandom));
  endtask

  task automatic random_items(int n);
    int k, lim;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      lim = sb.active_bins() + 2;
      if (lim > 1023) lim = 1023;
      if (k < 60) random_point();
      else if (k < 93)
        send(pcps_pkg::OP_READ, 16'($urandom), 16'($urandom),
             ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, lim)));
      else if (k < 97)
        send(pcps_pkg::OP_CLEAR, 16'($urandom), 16'($urandom), 10'($urandom));
      else send(pcps_pkg::OP_NONE, 16'($urandom), 16'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    op = pcps_pkg::OP_CLEAR;
    px = '0;
    py = '0;
    rbin = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    valid_high = 0;
    burst_left = 0;
    hold_req = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    configure(-25736, 143, 100, 30000, 360);
    send(pcps_pkg::OP_CLEAR, 0, 0, 0);
    send(pcps_pkg::OP_POINT, 16'sd32767, 16'sd0, 0);
    send(pcps_pkg::OP_POINT, 16'sd0, 16'sd32767, 0);
    send(pcps_pkg::OP_POINT, -16'sd32768, 16'sd0, 0);
    send(pcps_pkg::OP_POINT, 16'sd0, -16'sd32768, 0);
    send(pcps_pkg::OP_POINT, -16'sd32768, -16'sd32768, 0);
    send(pcps_pkg::OP_POINT, 16'sd1000, 16'sd1000, 0);
    send(pcps_pkg::OP_POINT, -16'sd500, 16'sd700, 0);
    send(pcps_pkg::OP_POINT, 16'sd50, 16'sd0, 0);
    send(pcps_pkg::OP_POINT, 16'sd0, 16'sd0, 0);
    send(pcps_pkg::OP_NONE, 16'sd1000, 16'sd0, 10'd5);
    send(pcps_pkg::OP_READ, 0, 0, 10'd0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd90);
    send(pcps_pkg::OP_READ, 0, 0, 10'd179);
    send(pcps_pkg::OP_READ, 0, 0, 10'd180);
    send(pcps_pkg::OP_READ, 0, 0, 10'd359);
    send(pcps_pkg::OP_READ, 0, 0, 10'd360);
    send(pcps_pkg::OP_READ, 0, 0, 10'd1023);
    send(pcps_pkg::OP_CLEAR, 0, 0, 0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd180);
    random_items(130);

    configure(25736, 8192, 0, 65535, 1024);
    send(pcps_pkg::OP_POINT, 16'sd0, 16'sd0, 0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd1023);
    random_items(60);
    hold_req = 400;
    for (int i = 0; i < 12; i++) send(pcps_pkg::OP_READ, 0, 0, 10'($urandom));
    random_items(80);

    configure(0, 1, 0, 0, 1);
    send(pcps_pkg::OP_POINT, 16'sd0, 16'sd0, 0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd1);
    random_items(140);

    configure(-25736, 0, 65534, 65534, 2047);
    random_items(140);

    configure(12868, 1, 0, 65534, 0);
    send(pcps_pkg::OP_READ, 0, 0, 10'd0);
    random_items(60);

    for (int p = 0; p < 8; p++) begin
      configure($urandom_range(0, 51472) - 25736, $urandom_range(1, 400),
                $urandom_range(0, 2000), $urandom_range(20000, 65534),
                $urandom_range(1, 1024));
      send(pcps_pkg::OP_CLEAR, 0, 0, 0);
      random_items(70);
      if (p == 2) wait_drained();
      random_items(70);
    end

    wait_drained();
    repeat (1200) @(posedge clk);
    if (sb.expected.size() != 0) sb.errors++;
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### point_cloud_to_polar_scan.f
sv/pcps_pkg.sv
sv/pcps_ram.sv
sv/pcps_atan_rom.sv
sv/pcps_iter.sv
sv/point_cloud_to_polar_scan.sv
tb/point_cloud_to_polar_scan_tb.sv
